/* hw/rtl/pfa_pkg.sv */
package pfa_pkg;

  // Fixed field widths of the request and response.
  localparam int unsigned OP_W       = 3;
  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned STATUS_W   = 4;
  localparam int unsigned REF_OUT_W  = 8;
  localparam int unsigned FIRST_W    = 13;
  localparam int unsigned PAGE_SHIFT = 12;

  // Defaults for the top-level parameters.
  localparam int unsigned FRAMES_DEF   = 4096;
  localparam int unsigned REF_BITS_DEF = 8;

  // Command codes.
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 3'd0,
    OP_FREE    = 3'd1,
    OP_REF_INC = 3'd2,
    OP_REF_DEC = 3'd3,
    OP_INIT    = 3'd4
  } op_e;

  // Status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 4'd0,
    ST_EMPTY    = 4'd1,
    ST_REFNZ    = 4'd2,
    ST_DOUBLE   = 4'd3,
    ST_MISALIGN = 4'd4,
    ST_RANGE    = 4'd5,
    ST_UNDER    = 4'd6,
    ST_OVER     = 4'd7,
    ST_CORRUPT  = 4'd8
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_INIT
  } state_e;

  // Request and response payloads.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] phys_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    alloc_addr;
    logic [STATUS_W-1:0]  status;
    logic [REF_OUT_W-1:0] ref_after;
    logic                 released;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic exec;
    logic init_start;
    logic init_step;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic init_last;
  } dp_sts_t;

endpackage

/* hw/rtl/page_frame_allocator_core.sv */
// Page-frame allocator with per-frame reference counts. A request is taken when
// start_i is high and busy_o is low; each request produces exactly one response
// on rsp_o, marked by a single-cycle done_o pulse that the receiver must take
// in that cycle, since there is no way to hold it off. For alloc, free and the
// two reference operations the accept cycle reads the per-frame memory and the
// following cycle checks, writes back and updates the list head; done_o rises
// the cycle after that, with busy_o already low, so a new request can be taken
// while done_o is high. Init walks the frame memory through its single write
// port, one frame per cycle, keeping busy_o high up to the last write, and its
// response follows that write. The frame memory has no reset, so an init must
// be issued before any other operation. The user must write first_free_page
// (cfg_we_i, cfg_wdata_i) only while idle; the block does not enforce this.
module page_frame_allocator_core #(
  parameter int unsigned FRAMES   = pfa_pkg::FRAMES_DEF,
  parameter int unsigned REF_BITS = pfa_pkg::REF_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  pfa_pkg::req_t               req_i,
  output logic                        busy_o,
  output logic                        done_o,
  output pfa_pkg::rsp_t               rsp_o,
  input  logic                        cfg_we_i,
  input  logic [pfa_pkg::FIRST_W-1:0] cfg_wdata_i
);
  import pfa_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Sequencer for request accept, execute and the init walk.
  pfa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Frame memory, list head and response registers.
  pfa_datapath #(
    .FRAMES   (FRAMES),
    .REF_BITS (REF_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o),
    .done_o      (done_o)
  );

endmodule

/* hw/rtl/pfa_ctrl.sv */
module pfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  pfa_pkg::req_t     req_i,
  input  pfa_pkg::dp_sts_t  sts_i,
  output pfa_pkg::ctrl_cmd_t cmd_o,
  output logic              busy_o
);
  import pfa_pkg::*;

  state_e state_q, state_d;
  logic   accept;
  logic   is_init;

  assign accept  = (state_q == S_IDLE) && start_i;
  assign is_init = (req_i.op == OP_INIT);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = is_init ? S_INIT : S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      S_INIT: begin
        if (sts_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Command outputs to the datapath.
  always_comb begin
    cmd_o = '0;
    busy_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy_o           = 1'b0;
        cmd_o.capture    = accept;
        cmd_o.init_start = accept && is_init;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      S_INIT: begin
        cmd_o.init_step = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/pfa_datapath.sv */
module pfa_datapath #(
  parameter int unsigned FRAMES   = pfa_pkg::FRAMES_DEF,
  parameter int unsigned REF_BITS = pfa_pkg::REF_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pfa_pkg::req_t               req_i,
  input  logic                        cfg_we_i,
  input  logic [pfa_pkg::FIRST_W-1:0] cfg_wdata_i,
  input  pfa_pkg::ctrl_cmd_t          cmd_i,
  output pfa_pkg::dp_sts_t            sts_o,
  output pfa_pkg::rsp_t               rsp_o,
  output logic                        done_o
);
  import pfa_pkg::*;

  localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned PTR_W = $clog2(FRAMES + 1);
  localparam logic [31:0] FRAMES32 = 32'(FRAMES);
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  typedef struct packed {
    logic [PTR_W-1:0]    nxt;
    logic [REF_BITS-1:0] cnt;
    logic                free;
  } entry_t;

  // Per-frame store: next pointer, reference count and free mark.
  entry_t frame_mem_q [FRAMES];

  entry_t                rd_q;
  logic   [OP_W-1:0]     op_q;
  logic   [ADDR_W-1:0]   addr_q;
  logic   [PTR_W-1:0]    head_q, head_d;
  logic   [FIRST_W-1:0]  ffp_q;
  logic   [IDX_W-1:0]    cursor_q;
  rsp_t                  rsp_q, rsp_d;
  logic                  done_q, done_d;

  logic   [IDX_W-1:0]    rd_idx;
  logic   [31:0]         in_frame32;
  logic                  mem_we;
  logic   [IDX_W-1:0]    mem_wa;
  entry_t                mem_wd;

  // Read address for the accepted request: list head for alloc, else the addressed frame.
  always_comb begin
    in_frame32 = 32'(req_i.phys_addr[ADDR_W-1:PAGE_SHIFT]);
    if (req_i.op == OP_ALLOC) begin
      rd_idx = head_q[IDX_W-1:0];
    end else begin
      rd_idx = in_frame32[IDX_W-1:0];
    end
  end

  // Registered memory read and request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_q   <= frame_mem_q[rd_idx];
      op_q   <= req_i.op;
      addr_q <= req_i.phys_addr;
    end
  end

  // Memory write port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem_q[mem_wa] <= mem_wd;
    end
  end

  assign sts_o.init_last = (32'(cursor_q) == (FRAMES32 - 32'd1));

  // Execute step and init walk: checks, memory write, head update, response.
  always_comb begin
    logic [31:0]         frame32;
    logic [31:0]         head32;
    logic [31:0]         cur32;
    logic [31:0]         ffp32;
    logic [IDX_W-1:0]    f_idx;
    logic                in_range;
    logic [REF_BITS-1:0] cnt;
    logic [REF_BITS-1:0] newc;
    logic [REF_BITS-1:0] refa;
    status_e             st;
    logic                rel;
    logic [ADDR_W-1:0]   aaddr;

    frame32  = 32'(addr_q[ADDR_W-1:PAGE_SHIFT]);
    head32   = 32'(head_q);
    cur32    = 32'(cursor_q);
    ffp32    = 32'(ffp_q);
    f_idx    = frame32[IDX_W-1:0];
    in_range = (frame32 < FRAMES32);
    cnt      = rd_q.cnt;
    newc     = cnt - REF_BITS'(1);
    refa     = '0;
    st       = ST_OK;
    rel      = 1'b0;
    aaddr    = '0;

    head_d = head_q;
    mem_we = 1'b0;
    mem_wa = f_idx;
    mem_wd = rd_q;
    done_d = 1'b0;
    rsp_d  = '0;

    if (cmd_i.exec) begin
      done_d = 1'b1;
      case (op_q)
        OP_ALLOC: begin
          mem_wa = head_q[IDX_W-1:0];
          if (head32 >= FRAMES32) begin
            st = ST_EMPTY;
          end else if (!rd_q.free || (cnt != '0)) begin
            st   = ST_CORRUPT;
            refa = cnt;
          end else begin
            mem_we      = 1'b1;
            mem_wd.free = 1'b0;
            mem_wd.cnt  = REF_BITS'(1);
            head_d      = rd_q.nxt;
            aaddr       = ADDR_W'({head32, {PAGE_SHIFT{1'b0}}});
            refa        = REF_BITS'(1);
          end
        end
        OP_FREE: begin
          if (!in_range) begin
            st = ST_RANGE;
          end else begin
            refa = cnt;
            if (cnt != '0) begin
              st = ST_REFNZ;
            end else if (rd_q.free) begin
              st = ST_DOUBLE;
            end else if (addr_q[PAGE_SHIFT-1:0] != '0) begin
              st = ST_MISALIGN;
            end else begin
              mem_we = 1'b1;
              mem_wd = '{nxt: head_q, cnt: '0, free: 1'b1};
              head_d = PTR_W'(frame32);
            end
          end
        end
        OP_REF_INC: begin
          if (!in_range) begin
            st = ST_RANGE;
          end else if (cnt == REF_MAX) begin
            st   = ST_OVER;
            refa = cnt;
          end else begin
            mem_we     = 1'b1;
            mem_wd.cnt = cnt + REF_BITS'(1);
            refa       = cnt + REF_BITS'(1);
          end
        end
        OP_REF_DEC: begin
          if (!in_range) begin
            st = ST_RANGE;
          end else if (cnt == '0) begin
            st = ST_UNDER;
          end else if ((cnt == REF_BITS'(1)) && rd_q.free) begin
            st   = ST_DOUBLE;
            refa = cnt;
          end else if (newc == '0) begin
            // Last reference dropped: the frame goes back on the list.
            mem_we = 1'b1;
            mem_wd = '{nxt: head_q, cnt: '0, free: 1'b1};
            head_d = PTR_W'(frame32);
            rel    = 1'b1;
          end else begin
            mem_we     = 1'b1;
            mem_wd.cnt = newc;
            refa       = newc;
          end
        end
        default: begin
          // Unused codes answer with an all-zero response.
          st = ST_OK;
        end
      endcase
      rsp_d.alloc_addr = aaddr;
      rsp_d.status     = st;
      rsp_d.ref_after  = REF_OUT_W'(32'(refa));
      rsp_d.released   = rel;
    end else if (cmd_i.init_step) begin
      // One frame a cycle: reserved frames are cleared, the rest chained upward.
      mem_we = 1'b1;
      mem_wa = cursor_q;
      if (cur32 < ffp32) begin
        mem_wd = '{nxt: '0, cnt: '0, free: 1'b0};
      end else begin
        mem_wd = '{nxt: PTR_W'(cur32 + 32'd1), cnt: '0, free: 1'b1};
      end
      if (sts_o.init_last) begin
        done_d = 1'b1;
        head_d = (ffp32 < FRAMES32) ? PTR_W'(ffp32) : PTR_W'(FRAMES32);
      end
    end
  end

  // Control registers: list head, init cursor, configuration, response strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= PTR_W'(FRAMES32);
      cursor_q <= '0;
      ffp_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      head_q <= head_d;
      done_q <= done_d;
      if (cfg_we_i) begin
        ffp_q <= cfg_wdata_i;
      end
      if (cmd_i.init_start) begin
        cursor_q <= '0;
      end else if (cmd_i.init_step && !sts_o.init_last) begin
        cursor_q <= cursor_q + IDX_W'(1);
      end
    end
  end

  // Response payload register.
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule
